FILE: hdl/mavt_pkg.sv
// Shared types and constants for the multi-turn angle and velocity tracker.
// No dependencies; every other file in hdl/ refers to this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package mavt_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_ANGLE     = 2'd0;
    localparam logic [1:0] OP_VELOCITY  = 2'd1;
    localparam logic [1:0] OP_CALIBRATE = 2'd2;

    localparam int ANGLE_W = 12;
    localparam int TURN_W  = 16;
    localparam int INTV_W  = 20;
    localparam int POS_W   = 29;
    localparam int VEL_W   = 32;
    localparam int DELTA_W = ANGLE_W + 1;      // signed angle step
    localparam int DIFF_W  = ANGLE_W + 2;      // signed position change
    localparam int MAG_W   = ANGLE_W + 1;      // |position change| <= 8191
    localparam int PROD_W  = 33;               // 8191 * 1e6 < 2**33

    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic signed [DELTA_W-1:0] HALF_TURN_POS = 13'sd2048;
    localparam logic signed [DELTA_W-1:0] HALF_TURN_NEG = -13'sd2048;
    localparam logic signed [DIFF_W-1:0]  ONE_TURN      = 14'sd4096;
    localparam logic signed [TURN_W-1:0]  TURN_MAX      = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0]  TURN_MIN      = 16'sh8000;
    localparam logic [INTV_W-1:0]         US_PER_S      = 20'd1000000;
    localparam logic [PROD_W-1:0]         VEL_LIMIT     = 33'd2048000000;

    typedef struct packed {
        logic [1:0]         operation;
        logic [ANGLE_W-1:0] raw_angle;
        logic [INTV_W-1:0]  interval_us;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
    } t_out_item;

    // Work handed from the front to the back
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    do_div;
        logic                    diff_neg;
        logic [MAG_W-1:0]        diff_mag;
        logic [INTV_W-1:0]       interval_us;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

`default_nettype wire

FILE: hdl/mavt_front.sv
// Front end: holds direction sense, turn count and last angle; unwraps each
// sample combinationally and emits a job. Depends on mavt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mavt_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_data,
    input  wire logic               i_accept,
    input  wire mavt_pkg::t_in_item i_item,
    output mavt_pkg::t_job          o_job
);

    logic                                   r_dir;
    logic signed [mavt_pkg::TURN_W-1:0]     r_turn;
    logic [mavt_pkg::ANGLE_W-1:0]           r_last;
    logic signed [mavt_pkg::TURN_W-1:0]     n_turn;
    logic [mavt_pkg::ANGLE_W-1:0]           n_last;

    logic signed [mavt_pkg::DELTA_W-1:0]    delta;
    logic                                   wrap_lo;
    logic                                   wrap_hi;
    logic                                   inc;
    logic                                   dec;
    logic signed [mavt_pkg::TURN_W-1:0]     uw_turn;
    logic signed [mavt_pkg::DIFF_W-1:0]     diff;
    logic signed [mavt_pkg::DIFF_W-1:0]     neg_diff;
    logic                                   do_div;

    always_comb begin
        delta   = $signed({1'b0, i_item.raw_angle}) - $signed({1'b0, r_last});
        wrap_lo = (delta <= mavt_pkg::HALF_TURN_NEG);
        wrap_hi = (delta >= mavt_pkg::HALF_TURN_POS);
        // sense 0: falling wrap adds a turn; sense 1: rising wrap adds a turn
        inc = (r_dir ? wrap_hi : wrap_lo) && (r_turn != mavt_pkg::TURN_MAX);
        dec = (r_dir ? wrap_lo : wrap_hi) && (r_turn != mavt_pkg::TURN_MIN);
        uw_turn = inc ? r_turn + 16'sd1 : (dec ? r_turn - 16'sd1 : r_turn);
        diff = {delta[mavt_pkg::DELTA_W-1], delta}
             + (inc ? mavt_pkg::ONE_TURN : (dec ? -mavt_pkg::ONE_TURN : 14'sd0));
        neg_diff = -diff;

        n_turn = r_turn;
        n_last = r_last;
        do_div = 1'b0;
        unique case (i_item.operation)
            mavt_pkg::OP_ANGLE: begin
                n_turn = uw_turn;
                n_last = i_item.raw_angle;
            end
            mavt_pkg::OP_VELOCITY: begin
                if (i_item.interval_us != '0) begin
                    n_turn = uw_turn;
                    n_last = i_item.raw_angle;
                    do_div = 1'b1;
                end
            end
            mavt_pkg::OP_CALIBRATE: begin
                n_turn = '0;
                n_last = i_item.raw_angle;
            end
            default: begin
            end
        endcase

        o_job.position    = $signed({n_turn[mavt_pkg::TURN_W-1], n_turn, n_last});
        o_job.do_div      = do_div;
        o_job.diff_neg    = diff[mavt_pkg::DIFF_W-1];
        o_job.diff_mag    = diff[mavt_pkg::DIFF_W-1] ? neg_diff[mavt_pkg::MAG_W-1:0]
                                                     : diff[mavt_pkg::MAG_W-1:0];
        o_job.interval_us = i_item.interval_us;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= 1'b0;
            r_turn <= '0;
            r_last <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dir <= i_cfg_data;
            end
            if (i_accept) begin
                r_turn <= n_turn;
                r_last <= n_last;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mavt_queue.sv
// Two-entry job queue between front and back end.
// Depends on mavt_pkg for the job and status types.
`timescale 1ns / 1ps
`default_nettype none

module mavt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mavt_pkg::t_job i_job,
    input  wire logic           i_pop,
    output mavt_pkg::t_job      o_job,
    output mavt_pkg::t_q_stat   o_stat
);

    mavt_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mavt_back.sv
// Back end: scales the position change by 1e6 and divides by the interval
// with a one-bit-per-cycle restoring divider. Depends on mavt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mavt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mavt_pkg::t_job    i_job,
    input  wire mavt_pkg::t_q_stat i_q_stat,
    output logic                   o_q_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output mavt_pkg::t_out_item    o_res
);

    mavt_pkg::t_back_state                r_state;
    mavt_pkg::t_back_state                n_state;
    logic [mavt_pkg::CNT_W-1:0]           r_cnt;
    logic signed [mavt_pkg::POS_W-1:0]    r_pos;
    logic                                 r_neg;
    logic [mavt_pkg::MAG_W-1:0]           r_mag;
    logic [mavt_pkg::INTV_W-1:0]          r_intv;
    logic [mavt_pkg::INTV_W-1:0]          r_rem;
    logic [mavt_pkg::PROD_W-1:0]          r_quo;

    logic [mavt_pkg::PROD_W-1:0]          prod;
    logic [mavt_pkg::INTV_W:0]            shifted;
    logic [mavt_pkg::INTV_W:0]            trial;
    logic                                 ge;
    logic [mavt_pkg::PROD_W-1:0]          sat;
    logic [mavt_pkg::VEL_W-1:0]           mag32;

    assign prod    = {{(mavt_pkg::PROD_W-mavt_pkg::MAG_W){1'b0}}, r_mag}
                   * {{(mavt_pkg::PROD_W-mavt_pkg::INTV_W){1'b0}}, mavt_pkg::US_PER_S};
    assign shifted = {r_rem, r_quo[mavt_pkg::PROD_W-1]};
    assign ge      = (shifted >= {1'b0, r_intv});
    assign trial   = shifted - {1'b0, r_intv};
    assign sat     = (r_quo > mavt_pkg::VEL_LIMIT) ? mavt_pkg::VEL_LIMIT : r_quo;
    assign mag32   = sat[mavt_pkg::VEL_W-1:0];

    assign o_res.position = r_pos;
    assign o_res.velocity = r_neg ? -$signed(mag32) : $signed(mag32);

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            mavt_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop = 1'b1;
                    n_state = i_job.do_div ? mavt_pkg::BK_MUL : mavt_pkg::BK_DONE;
                end
            end
            mavt_pkg::BK_MUL: begin
                n_state = mavt_pkg::BK_DIV;
            end
            mavt_pkg::BK_DIV: begin
                if (r_cnt == mavt_pkg::CNT_W'(mavt_pkg::DIV_STEPS - 1)) begin
                    n_state = mavt_pkg::BK_DONE;
                end
            end
            mavt_pkg::BK_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = mavt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = mavt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mavt_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mavt_pkg::BK_IDLE: begin
                r_pos  <= i_job.position;
                r_neg  <= i_job.diff_neg;
                r_mag  <= i_job.diff_mag;
                r_intv <= i_job.interval_us;
                r_quo  <= '0;
            end
            mavt_pkg::BK_MUL: begin
                r_quo <= prod;
                r_rem <= '0;
                r_cnt <= '0;
            end
            mavt_pkg::BK_DIV: begin
                r_rem <= ge ? trial[mavt_pkg::INTV_W-1:0] : shifted[mavt_pkg::INTV_W-1:0];
                r_quo <= {r_quo[mavt_pkg::PROD_W-2:0], ge};
                r_cnt <= r_cnt + mavt_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/multiturn_angle_velocity_tracker.sv
// Multi-turn angle and velocity tracker, top level: front end, job queue,
// back end and output register. Depends on mavt_pkg, mavt_front, mavt_queue, mavt_back.
//
// Takes 12-bit absolute encoder samples (4096 counts a turn) through a queue-style
// push/full port and returns one result per item through empty/pop. The front end
// unwraps each sample against the previous one in the cycle it is accepted: a step
// of half a turn or more moves the saturating 16-bit turn count by one, in the
// direction chosen by the direction sense register. In the back end, angle reads
// and calibrates go from IDLE straight to DONE. A velocity read with a nonzero
// interval is loaded in IDLE, scaled by one million (13 x 20 bit) in MUL, divided
// in DIV by the restoring divider (one quotient bit per cycle) and handed over
// from DONE; the back end takes the next job from the queue only once DONE has
// handed its result over. Two jobs queue between front and back and one finished
// result waits in the output register, so up to four items can be in flight. The
// direction sense register is written through cfg_valid/cfg_ready, which is
// always ready; write it only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module multiturn_angle_velocity_tracker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input side
    input  wire logic                push,
    output logic                     full,
    input  wire mavt_pkg::t_in_item  i_in_item,
    // result side
    output logic                     empty,
    input  wire logic                pop,
    output mavt_pkg::t_out_item      o_out_item,
    // configuration
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data
);

    mavt_pkg::t_job      front_job;
    mavt_pkg::t_job      q_job;
    mavt_pkg::t_q_stat   q_stat;
    logic                in_xfer;
    logic                q_pop;
    logic                res_valid;
    logic                res_ready;
    mavt_pkg::t_out_item res;

    logic                r_out_valid;
    mavt_pkg::t_out_item r_out_item;

    // An item transfer happens whenever push is high and the queue has room.
    assign full        = q_stat.full;
    assign in_xfer     = push && !q_stat.full;
    assign o_cfg_ready = 1'b1;

    mavt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_xfer),
        .i_item      (i_in_item),
        .o_job       (front_job)
    );

    mavt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    mavt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_q_stat    (q_stat),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register: refills in the same cycle as the waiting result is popped.
    assign res_ready  = !r_out_valid || pop;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out_item;

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_item <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    // Back end never takes a job from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end popped an empty job queue");

    // An empty queue is never full in the cycle after.
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |=> !q_stat.full)
        else $error("job queue filled by more than one transfer per cycle");

    // A waiting result is only overwritten when it is popped.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> ($stable(r_out_item) && r_out_valid))
        else $error("waiting result overwritten");

    // Nothing is presented straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && q_stat.empty))
        else $error("result or job present after reset");

endmodule

`default_nettype wire
